### rtl/gtdp_pkg.sv
// Shared types and constants of the greedy track-to-detection pairing block.
// No dependencies; used by the channel interfaces and the top level.
package gtdp_pkg;

  localparam int COST_W = 24;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;

  localparam int MAX_TRACKS_DEF     = 16;
  localparam int MAX_DETECTIONS_DEF = 16;

  localparam logic [COST_W-1:0] THRESH_RESET = COST_W'(256);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_RUN   = 1'b1;

  typedef enum logic [1:0] {
    OC_UPDATE   = 2'd0,
    OC_NEW_PAIR = 2'd1,
    OC_UNPAIRED = 2'd2
  } outcome_e;

endpackage

### rtl/gtdp_if.sv
// Valid/ready channel interfaces: configuration, input item and result item.
// Depends on gtdp_pkg for field widths and the outcome code type.
interface gtdp_cfg_if import gtdp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gtdp_in_if import gtdp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [IDX_W-1:0]  track_index;
  logic [IDX_W-1:0]  detection_index;
  logic [COST_W-1:0] cost;
  logic [CNT_W-1:0]  track_count;
  logic [CNT_W-1:0]  detection_count;

  modport source (output valid, output command, output track_index, output detection_index,
                  output cost, output track_count, output detection_count, input ready);
  modport sink   (input valid, input command, input track_index, input detection_index,
                  input cost, input track_count, input detection_count, output ready);
endinterface

interface gtdp_out_if import gtdp_pkg::*; ();
  logic              valid;
  logic              ready;
  outcome_e          outcome;
  logic [IDX_W-1:0]  paired_track;
  logic [IDX_W-1:0]  paired_detection;
  logic [COST_W-1:0] pair_cost;
  logic              last;

  modport source (output valid, output outcome, output paired_track, output paired_detection,
                  output pair_cost, output last, input ready);
  modport sink   (input valid, input outcome, input paired_track, input paired_detection,
                  input pair_cost, input last, output ready);
endinterface

### rtl/gtdp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gtdp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/greedy_track_detection_pairing.sv
// Top level of the greedy track-to-detection pairing block.
// Depends on gtdp_pkg, the channel interfaces in gtdp_if and gtdp_ram.
//
// Channels: cfg_i writes match_threshold (always ready, reset 256). in_i takes
// a beat that either writes one cost entry (command 0) or starts a run
// (command 1) with track and detection counts. out_o gives one result beat per
// detection of the run; last marks the final one.
// A run scans the cost memory once per pairing round, one entry per cycle
// through the memory's single read port and one 24-bit comparator. There are up
// to min(tc, dc) rounds plus one empty round when 0 < tc < dc, then a pass over
// the detections emits the unpaired ones. in_i is not ready while a run is in
// progress and is ready again in the cycle after the last result is loaded.
// Reset clears the sequencer, the used masks and the output register; the
// cost memory holds no defined value until written.
// When the receiver stalls, the sequencer waits at its emit or unpaired step
// with the pending result held in the output register.
module greedy_track_detection_pairing import gtdp_pkg::*; #(
  parameter int MAX_TRACKS     = MAX_TRACKS_DEF,
  parameter int MAX_DETECTIONS = MAX_DETECTIONS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gtdp_cfg_if.sink    cfg_i,
  gtdp_in_if.sink     in_i,
  gtdp_out_if.source  out_o
);

  localparam int TW    = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int DW    = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
  localparam int TCW   = $clog2(MAX_TRACKS + 1);
  localparam int DCW   = $clog2(MAX_DETECTIONS + 1);
  localparam int AW    = TW + DW;
  localparam int DEPTH = 2 ** AW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETTLE,
    ST_EMIT,
    ST_UNPAIRED
  } state_e;

  state_e                  state_q;
  logic [COST_W-1:0]       thresh_q;
  logic [TCW-1:0]          tc_q;
  logic [DCW-1:0]          dc_q;
  logic [DCW-1:0]          emit_q;
  logic [TW-1:0]           t_q;
  logic [DW-1:0]           d_q;
  logic [MAX_TRACKS-1:0]     trk_used_q;
  logic [MAX_DETECTIONS-1:0] det_used_q;
  logic                    rd_vld_q;
  logic [TW-1:0]           rd_t_q;
  logic [DW-1:0]           rd_d_q;
  logic                    found_q;
  logic [COST_W-1:0]       best_q;
  logic [TW-1:0]           best_t_q;
  logic [DW-1:0]           best_d_q;
  logic                    out_vld_q;
  outcome_e                out_oc_q;
  logic [IDX_W-1:0]        out_trk_q;
  logic [IDX_W-1:0]        out_det_q;
  logic [COST_W-1:0]       out_cost_q;
  logic                    out_last_q;

  logic              in_fire;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [COST_W-1:0] rd_data;
  logic              rd_vld_d;
  logic [TCW-1:0]    tc_sat;
  logic [DCW-1:0]    dc_sat;
  logic              t_end;
  logic              d_end;
  logic              res_last;
  logic              out_free;
  logic              emit_pair;
  logic              emit_unp;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;

  assign wr_en   = in_fire && (in_i.command == CMD_WRITE)
                && (32'(in_i.track_index) < MAX_TRACKS)
                && (32'(in_i.detection_index) < MAX_DETECTIONS);
  assign wr_addr = {TW'(in_i.track_index), DW'(in_i.detection_index)};
  assign rd_addr = {t_q, d_q};

  assign tc_sat = (32'(in_i.track_count) > MAX_TRACKS) ? TCW'(MAX_TRACKS)
                                                       : TCW'(in_i.track_count);
  assign dc_sat = (32'(in_i.detection_count) > MAX_DETECTIONS) ? DCW'(MAX_DETECTIONS)
                                                               : DCW'(in_i.detection_count);

  assign t_end    = ((TCW+1)'(t_q) + (TCW+1)'(1)) == (TCW+1)'(tc_q);
  assign d_end    = ((DCW+1)'(d_q) + (DCW+1)'(1)) == (DCW+1)'(dc_q);
  assign res_last = ((DCW+1)'(emit_q) + (DCW+1)'(1)) == (DCW+1)'(dc_q);
  assign out_free = !out_vld_q || out_o.ready;

  assign rd_vld_d  = (state_q == ST_SCAN) && !trk_used_q[t_q] && !det_used_q[d_q];
  assign emit_pair = (state_q == ST_EMIT) && found_q && out_free;
  assign emit_unp  = (state_q == ST_UNPAIRED) && !det_used_q[d_q] && out_free;

  gtdp_ram #(
    .WIDTH (COST_W),
    .DEPTH (DEPTH)
  ) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (in_i.cost),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      thresh_q   <= THRESH_RESET;
      tc_q       <= '0;
      dc_q       <= '0;
      emit_q     <= '0;
      t_q        <= '0;
      d_q        <= '0;
      trk_used_q <= '0;
      det_used_q <= '0;
      rd_vld_q   <= 1'b0;
      rd_t_q     <= '0;
      rd_d_q     <= '0;
      found_q    <= 1'b0;
      best_q     <= '0;
      best_t_q   <= '0;
      best_d_q   <= '0;
      out_vld_q  <= 1'b0;
      out_oc_q   <= OC_UPDATE;
      out_trk_q  <= '0;
      out_det_q  <= '0;
      out_cost_q <= '0;
      out_last_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        thresh_q <= cfg_i.data;
      end

      rd_vld_q <= rd_vld_d;
      rd_t_q   <= t_q;
      rd_d_q   <= d_q;
      if (rd_vld_q && (!found_q || rd_data < best_q)) begin
        found_q  <= 1'b1;
        best_q   <= rd_data;
        best_t_q <= rd_t_q;
        best_d_q <= rd_d_q;
      end

      if (out_o.ready && !(emit_pair || emit_unp)) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && in_i.command == CMD_RUN) begin
            tc_q       <= tc_sat;
            dc_q       <= dc_sat;
            emit_q     <= '0;
            t_q        <= '0;
            d_q        <= '0;
            trk_used_q <= '0;
            det_used_q <= '0;
            found_q    <= 1'b0;
            if (dc_sat == '0) begin
              state_q <= ST_IDLE;
            end else if (tc_sat == '0) begin
              state_q <= ST_UNPAIRED;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (t_end) begin
            t_q <= '0;
            if (d_end) begin
              state_q <= ST_SETTLE;
            end else begin
              d_q <= d_q + DW'(1);
            end
          end else begin
            t_q <= t_q + TW'(1);
          end
        end
        ST_SETTLE: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!found_q) begin
            d_q     <= '0;
            state_q <= ST_UNPAIRED;
          end else if (out_free) begin
            out_vld_q  <= 1'b1;
            out_oc_q   <= (best_q < thresh_q) ? OC_UPDATE : OC_NEW_PAIR;
            out_trk_q  <= IDX_W'(best_t_q);
            out_det_q  <= IDX_W'(best_d_q);
            out_cost_q <= best_q;
            out_last_q <= res_last;
            trk_used_q[best_t_q] <= 1'b1;
            det_used_q[best_d_q] <= 1'b1;
            emit_q     <= emit_q + DCW'(1);
            found_q    <= 1'b0;
            t_q        <= '0;
            d_q        <= '0;
            state_q    <= res_last ? ST_IDLE : ST_SCAN;
          end
        end
        ST_UNPAIRED: begin
          if (det_used_q[d_q] || out_free) begin
            if (!det_used_q[d_q]) begin
              out_vld_q  <= 1'b1;
              out_oc_q   <= OC_UNPAIRED;
              out_trk_q  <= '0;
              out_det_q  <= IDX_W'(d_q);
              out_cost_q <= '0;
              out_last_q <= res_last;
              emit_q     <= emit_q + DCW'(1);
            end
            if (d_end || (!det_used_q[d_q] && res_last)) begin
              state_q <= ST_IDLE;
            end else begin
              d_q <= d_q + DW'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.outcome          = out_oc_q;
  assign out_o.paired_track     = out_trk_q;
  assign out_o.paired_detection = out_det_q;
  assign out_o.pair_cost        = out_cost_q;
  assign out_o.last             = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_pair |-> !trk_used_q[best_t_q] && !det_used_q[best_d_q])
    else $error("pair emitted on a used track or detection");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (emit_q < dc_q))
    else $error("more results than detections in a run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_pair || emit_unp) |=> out_vld_q && ($past(res_last) == out_last_q))
    else $error("result beat not loaded or last flag wrong");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (32'(best_t_q) < 32'(tc_q)) && (32'(best_d_q) < 32'(dc_q)))
    else $error("best pair outside the run counts");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |=> out_vld_q && $stable(out_cost_q) && $stable(out_det_q))
    else $error("stalled result beat overwritten");

endmodule

### bench/gtdp_pairing_checker.sv
// Checker for the greedy track-to-detection pairing block: watches the three
// channels, predicts every result beat and compares it field by field.
// Depends on gtdp_pkg and the channel interfaces in gtdp_if.
module gtdp_pairing_checker import gtdp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  gtdp_cfg_if  cfg_i,
  gtdp_in_if   in_i,
  gtdp_out_if  res_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT = MAX_TRACKS_DEF;
  localparam int ND = MAX_DETECTIONS_DEF;

  typedef struct {
    outcome_e          outcome;
    logic [IDX_W-1:0]  track;
    logic [IDX_W-1:0]  detection;
    logic [COST_W-1:0] cost;
    logic              last;
  } pairing_t;

  logic [COST_W-1:0] cost_mem [NT][ND];
  logic [COST_W-1:0] threshold;
  pairing_t          pairings_due [$];

  function automatic int clamp_count(input logic [CNT_W-1:0] raw, input int limit);
    return (int'(raw) > limit) ? limit : int'(raw);
  endfunction

  function automatic void predict_pairing(input logic [CNT_W-1:0] tc_raw, dc_raw);
    int                tc;
    int                dc;
    int                rounds;
    int                bt;
    int                bd;
    bit                found;
    logic [NT-1:0]     t_used;
    logic [ND-1:0]     d_used;
    logic [COST_W-1:0] best;
    pairing_t          frame [$];
    pairing_t          p;
    tc = clamp_count(tc_raw, NT);
    dc = clamp_count(dc_raw, ND);
    rounds = (tc < dc) ? tc : dc;
    t_used = '0;
    d_used = '0;
    for (int k = 0; k < rounds; k++) begin
      found = 1'b0;
      bt = 0;
      bd = 0;
      best = '0;
      for (int d = 0; d < dc; d++) begin
        if (!d_used[d]) begin
          for (int t = 0; t < tc; t++) begin
            if (!t_used[t] && (!found || cost_mem[t][d] < best)) begin
              found = 1'b1;
              best = cost_mem[t][d];
              bt = t;
              bd = d;
            end
          end
        end
      end
      t_used[bt] = 1'b1;
      d_used[bd] = 1'b1;
      p.outcome = (best < threshold) ? OC_UPDATE : OC_NEW_PAIR;
      p.track = IDX_W'(bt);
      p.detection = IDX_W'(bd);
      p.cost = best;
      p.last = 1'b0;
      frame = {frame, p};
    end
    for (int d = 0; d < dc; d++) begin
      if (!d_used[d]) begin
        p.outcome = OC_UNPAIRED;
        p.track = '0;
        p.detection = IDX_W'(d);
        p.cost = '0;
        p.last = 1'b0;
        frame = {frame, p};
      end
    end
    if (frame.size() > 0) frame[frame.size() - 1].last = 1'b1;
    foreach (frame[i]) pairings_due = {pairings_due, frame[i]};
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pairing_t want;
    if (!rst_ni) begin
      threshold = THRESH_RESET;
      pairings_due.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) threshold = cfg_i.data;
      if (in_i.valid && in_i.ready) begin
        if (in_i.command == CMD_WRITE) begin
          cost_mem[in_i.track_index][in_i.detection_index] = in_i.cost;
        end else begin
          predict_pairing(in_i.track_count, in_i.detection_count);
        end
      end
      if (res_i.valid && res_i.ready) begin
        if (pairings_due.size() == 0) begin
          $error("unexpected result beat: track %0d detection %0d cost %0d",
                 res_i.paired_track, res_i.paired_detection, res_i.pair_cost);
          fail_count_o++;
        end else begin
          want = pairings_due.pop_front();
          compare_field("outcome", 32'(want.outcome), 32'(res_i.outcome));
          compare_field("paired_track", 32'(want.track), 32'(res_i.paired_track));
          compare_field("paired_detection", 32'(want.detection),
                        32'(res_i.paired_detection));
          compare_field("pair_cost", 32'(want.cost), 32'(res_i.pair_cost));
          compare_field("last", 32'(want.last), 32'(res_i.last));
        end
      end
    end
    pending_o = pairings_due.size();
  end

endmodule

### bench/tb_top.sv
// Stimulus and verdict for the greedy track-to-detection pairing block.
// Depends on gtdp_pkg, the channel interfaces, the block and gtdp_pairing_checker.
module tb_top import gtdp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int DIRECTED_BEATS = 17;
  localparam int BLOCK_BEATS    = 37;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gtdp_cfg_if cfg_ch ();
  gtdp_in_if  in_ch ();
  gtdp_out_if out_ch ();

  greedy_track_detection_pairing dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  int fail_count;
  int pending;

  gtdp_pairing_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_i        (cfg_ch),
    .in_i         (in_ch),
    .res_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  idle_mode_e        idle_mode = IDLE_NONE;
  int                beats_sent = 0;
  int                cycles = 0;
  logic [COST_W-1:0] threshold_now = THRESH_RESET;
  logic [15:0]       cost_known [16];

  function automatic bit roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  always @(negedge clk) begin
    out_ch.ready <= !((idle_mode == IDLE_RECEIVER && roll(63)) ||
                      (idle_mode == IDLE_BOTH && roll(7)));
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return roll(63);
      IDLE_BOTH:   return roll(7);
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic [COST_W-1:0] pick_cost();
    int near;
    case ($urandom_range(0, 5))
      0: return COST_W'($urandom_range(0, 7));
      1: begin
        near = int'(threshold_now) + int'($urandom_range(0, 4)) - 2;
        if (near < 0) near = 0;
        if (near > 24'hFFFFFF) near = 24'hFFFFFF;
        return COST_W'(near);
      end
      2: return COST_W'($urandom);
      3: return '0;
      4: return '1;
      default: return COST_W'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic send_beat(input logic cmd, input logic [IDX_W-1:0] ti, di,
                           input logic [COST_W-1:0] c, input logic [CNT_W-1:0] tc, dc);
    while (sender_idles()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.track_index <= ti;
    in_ch.detection_index <= di;
    in_ch.cost <= c;
    in_ch.track_count <= tc;
    in_ch.detection_count <= dc;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    if (cmd == CMD_WRITE) cost_known[ti][di] = 1'b1;
    @(negedge clk);
  endtask

  task automatic write_cost(input logic [IDX_W-1:0] t, d, input logic [COST_W-1:0] c);
    send_beat(CMD_WRITE, t, d, c, CNT_W'($urandom), CNT_W'($urandom));
  endtask

  task automatic start_run(input logic [CNT_W-1:0] tc, dc);
    send_beat(CMD_RUN, IDX_W'($urandom), IDX_W'($urandom), COST_W'($urandom), tc, dc);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_threshold(input logic [COST_W-1:0] v);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    threshold_now = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Fill every entry the run will read, rewrite a few at random, then start it.
  task automatic pairing_frame(input logic [CNT_W-1:0] tc, dc);
    int tn;
    int dn;
    tn = (tc > 16) ? 16 : int'(tc);
    dn = (dc > 16) ? 16 : int'(dc);
    for (int t = 0; t < tn; t++) begin
      for (int d = 0; d < dn; d++) begin
        if (!cost_known[t][d]) write_cost(IDX_W'(t), IDX_W'(d), pick_cost());
      end
    end
    repeat ($urandom_range(0, 3)) write_cost(IDX_W'($urandom), IDX_W'($urandom), pick_cost());
    start_run(tc, dc);
  endtask

  task automatic random_frame();
    logic [CNT_W-1:0] tc;
    logic [CNT_W-1:0] dc;
    int               pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      tc = CNT_W'($urandom_range(16, 31));
      dc = CNT_W'($urandom_range(0, 2));
    end else if (pick < 4) begin
      tc = CNT_W'($urandom_range(0, 2));
      dc = CNT_W'($urandom_range(16, 31));
    end else if (pick < 6) begin
      tc = CNT_W'($urandom_range(8, 12));
      dc = CNT_W'($urandom_range(0, 3));
    end else if (pick < 7) begin
      tc = CNT_W'($urandom_range(0, 3));
      dc = CNT_W'($urandom_range(8, 12));
    end else begin
      tc = CNT_W'($urandom_range(0, 5));
      dc = CNT_W'($urandom_range(0, 5));
    end
    if ($urandom_range(0, 15) == 0) hold_until_drained();
    pairing_frame(tc, dc);
  endtask

  initial begin
    logic [COST_W-1:0] thr_pick;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_WRITE;
    in_ch.track_index = '0;
    in_ch.detection_index = '0;
    in_ch.cost = '0;
    in_ch.track_count = '0;
    in_ch.detection_count = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    foreach (cost_known[t]) cost_known[t] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    start_run(5'd0, 5'd0);
    start_run(5'd0, 5'd3);
    start_run(5'd31, 5'd0);
    write_cost(4'd0, 4'd0, 24'd256);
    write_cost(4'd1, 4'd0, 24'd256);
    write_cost(4'd2, 4'd0, 24'hFFFFFF);
    write_cost(4'd0, 4'd1, 24'hFFFFFF);
    write_cost(4'd1, 4'd1, 24'd255);
    write_cost(4'd2, 4'd1, 24'hFFFFFF);
    start_run(5'd3, 5'd2);
    write_cost(4'd0, 4'd2, 24'd0);
    write_cost(4'd1, 4'd2, 24'd256);
    start_run(5'd2, 5'd3);
    write_cost(4'd2, 4'd0, 24'd256);
    start_run(5'd3, 5'd1);
    write_cost(4'd15, 4'd15, 24'd0);
    start_run(5'd0, 5'd31);

    for (int blk = 0; blk < 8; blk++) begin
      case (blk)
        0: thr_pick = '0;
        1: thr_pick = '1;
        2: thr_pick = 24'd8;
        3: thr_pick = COST_W'($urandom);
        4: thr_pick = 24'd1;
        5: thr_pick = 24'hFFFFFE;
        6: thr_pick = COST_W'($urandom_range(0, 1023));
        default: thr_pick = COST_W'($urandom_range(0, 300));
      endcase
      set_threshold(thr_pick);
      idle_mode <= idle_mode_e'(blk % 4);
      while (beats_sent < DIRECTED_BEATS + (blk + 1) * BLOCK_BEATS) random_frame();
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
